### hdl/cala_pkg.sv
// ----------------------------------------------------------------------------
// cala_pkg
// Shared types and constants for the cost-augmented label argmax block.
// ----------------------------------------------------------------------------
package cala_pkg;

    // Defaults for the top-level parameters
    localparam int CALA_MAX_LABELS = 64;
    localparam int CALA_QUEUE_DEPTH = 4;

    // Fixed field widths
    localparam int SCORE_W = 32;
    localparam int WEIGHT_W = 17;
    localparam int ADJ_W = 34;
    localparam int PEN_W = 18;
    localparam int DELTA_W = 36;
    localparam int ACC_W = 48;
    localparam int LABEL_W = 6;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FP_WEIGHT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FN_WEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUGMENT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP = 8'd3;

    // Configuration reset values
    localparam logic [WEIGHT_W-1:0] FP_WEIGHT_RESET = 17'd32768;
    localparam logic [WEIGHT_W-1:0] FN_WEIGHT_RESET = 17'd32768;

    // Saturation limits of the accumulators
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [WEIGHT_W-1:0] fp_weight;
        logic [WEIGHT_W-1:0] fn_weight;
        logic                augment;
        logic                drop;
    } cala_cfg_t;

    // One classified item, as handed from front to back
    typedef struct packed {
        logic                     node_end;
        logic                     inst_end;
        logic                     augment;
        logic                     found;
        logic [LABEL_W-1:0]       label;
        logic [WEIGHT_W-1:0]      item_cost;
        logic signed [ADJ_W-1:0]  item_loss;
        logic signed [PEN_W-1:0]  win_pen;
        logic signed [SCORE_W-1:0] win_raw;
    } cala_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cala_qstat_t;

endpackage

### hdl/cost_augmented_label_argmax.sv
// ----------------------------------------------------------------------------
// cost_augmented_label_argmax
// Streaming cost-augmented argmax over the candidate labels of each node,
// with saturating Hamming cost and structured loss per instance.
// ----------------------------------------------------------------------------
// Path: a node-end beat passes the record queue, delta stage and result register.
// Throughput: one item per cycle while the queue has room; the front argmax compare
//   loop and the back saturating accumulate loop each close through one register.
// The front stalls only when the record queue is full (CALA_QUEUE_DEPTH).
// Reset: asynchronous, active low; clears the argmax state, the queue, the
//   accumulators and the config registers to their defaults. No clearing pass.
module cost_augmented_label_argmax
    import cala_pkg::*;
#(
    parameter int MaxLabels = CALA_MAX_LABELS,
    parameter int QueueDepth = CALA_QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Item channel
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic signed [SCORE_W-1:0] score,
    input  logic                      gold,
    input  logic                      last_in_node,
    input  logic                      last_in_instance,
    // Result channel
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [LABEL_W-1:0]        label_index,
    output logic                      label_found,
    output logic                      instance_end,
    output logic signed [ACC_W-1:0]   total_cost,
    output logic signed [ACC_W-1:0]   total_loss,
    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cala_cfg_t   cfg_reg, cfg_next;
    cala_rec_t   front_rec, queue_rec;
    cala_qstat_t qstat;
    logic        item_accept;
    logic        pop;

    // Config writes are always taken; ready is tied high
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FP_WEIGHT: cfg_next.fp_weight = cfg_data[WEIGHT_W-1:0];
                REG_FN_WEIGHT: cfg_next.fn_weight = cfg_data[WEIGHT_W-1:0];
                REG_AUGMENT:   cfg_next.augment   = cfg_data[0];
                REG_DROP:      cfg_next.drop      = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fp_weight <= FP_WEIGHT_RESET;
            cfg_reg.fn_weight <= FN_WEIGHT_RESET;
            cfg_reg.augment   <= 1'b1;
            cfg_reg.drop      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold the item side only while the queue has no free slot
    assign item_stall  = qstat.full;
    assign item_accept = item_valid && !item_stall;

    // Front: adjust, argmax, classify every beat into one record
    cala_front #(
        .MaxLabels (MaxLabels)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (item_accept),
        .score            (score),
        .gold             (gold),
        .last_in_node     (last_in_node),
        .last_in_instance (last_in_instance),
        .cfg              (cfg_reg),
        .rec              (front_rec)
    );

    // Decouple the two sides so either may stall on its own
    cala_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (item_accept),
        .wr_rec (front_rec),
        .pop    (pop),
        .rd_rec (queue_rec),
        .stat   (qstat)
    );

    // Back: sum terms, saturate into the accumulators, drive results
    cala_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_rec       (queue_rec),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .label_index  (label_index),
        .label_found  (label_found),
        .instance_end (instance_end),
        .total_cost   (total_cost),
        .total_loss   (total_loss)
    );

    // A null result always carries label zero
    a_null_label: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !label_found |-> label_index == '0)
        else $error("null result with nonzero label index");

    // Full and empty never both
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty");

    // An accepted beat always lands in the queue
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> !qstat.empty)
        else $error("accepted beat missing from queue");

    // Pop only from a nonempty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule

### hdl/cala_front.sv
// ----------------------------------------------------------------------------
// cala_front
// Adjust each score, track the first strict maximum of the node and
// classify the beat into a record for the accumulate side.
// ----------------------------------------------------------------------------
module cala_front
    import cala_pkg::*;
#(
    parameter int MaxLabels = CALA_MAX_LABELS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic signed [SCORE_W-1:0] score,
    input  logic                      gold,
    input  logic                      last_in_node,
    input  logic                      last_in_instance,
    input  cala_cfg_t                 cfg,
    output cala_rec_t                 rec
);

    localparam int CW = $clog2(MaxLabels + 1);
    localparam int PW = (MaxLabels > 1) ? $clog2(MaxLabels) : 1;

    logic [CW-1:0]             cnt_reg, cnt_next;
    logic signed [ADJ_W-1:0]   best_adj_reg, best_adj_next;
    logic signed [SCORE_W-1:0] best_raw_reg, best_raw_next;
    logic [PW-1:0]             best_pos_reg, best_pos_next;
    logic                      best_gold_reg, best_gold_next;

    logic signed [ADJ_W-1:0]   raw_x, a_x, b_x, adj;
    logic signed [ADJ_W-1:0]   cand_adj;
    logic signed [SCORE_W-1:0] cand_raw;
    logic [PW-1:0]             cand_pos;
    logic                      cand_gold;
    logic                      in_range, take, node_end, found;
    logic [PW+LABEL_W-1:0]     pos_wide;

    always_comb
    begin
        raw_x = {{(ADJ_W-SCORE_W){score[SCORE_W-1]}}, score};
        a_x   = {{(ADJ_W-WEIGHT_W){1'b0}}, cfg.fp_weight};
        b_x   = {{(ADJ_W-WEIGHT_W){1'b0}}, cfg.fn_weight};
        if (!cfg.augment)
        begin
            adj = raw_x;
        end
        else if (gold)
        begin
            adj = raw_x - b_x;
        end
        else
        begin
            adj = raw_x + a_x;
        end

        in_range = (cnt_reg < CW'(MaxLabels));
        take     = in_range && ((cnt_reg == '0) || (adj > best_adj_reg));
        node_end = last_in_node || last_in_instance;

        cand_adj  = take ? adj : best_adj_reg;
        cand_raw  = take ? score : best_raw_reg;
        cand_pos  = take ? cnt_reg[PW-1:0] : best_pos_reg;
        cand_gold = take ? gold : best_gold_reg;

        // At least one candidate was seen, so only the null drop can clear it
        found    = !(cfg.drop && (cand_adj[ADJ_W-1] || (cand_adj == '0)));
        pos_wide = {{LABEL_W{1'b0}}, cand_pos};

        rec.node_end  = node_end;
        rec.inst_end  = last_in_instance;
        rec.augment   = cfg.augment;
        rec.found     = node_end && found;
        rec.label     = (node_end && found) ? pos_wide[LABEL_W-1:0] : '0;
        rec.item_cost = (cfg.augment && gold) ? cfg.fn_weight : '0;
        rec.item_loss = (cfg.augment && gold) ? (b_x - raw_x) : '0;
        if (cfg.augment && node_end && found)
        begin
            rec.win_pen = cand_gold ? -{1'b0, cfg.fn_weight} : {1'b0, cfg.fp_weight};
            rec.win_raw = cand_raw;
        end
        else
        begin
            rec.win_pen = '0;
            rec.win_raw = '0;
        end

        cnt_next       = cnt_reg;
        best_adj_next  = best_adj_reg;
        best_raw_next  = best_raw_reg;
        best_pos_next  = best_pos_reg;
        best_gold_next = best_gold_reg;
        if (accept)
        begin
            if (node_end)
            begin
                cnt_next       = '0;
                best_adj_next  = '0;
                best_raw_next  = '0;
                best_pos_next  = '0;
                best_gold_next = 1'b0;
            end
            else
            begin
                cnt_next       = in_range ? cnt_reg + 1'b1 : cnt_reg;
                best_adj_next  = cand_adj;
                best_raw_next  = cand_raw;
                best_pos_next  = cand_pos;
                best_gold_next = cand_gold;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            best_adj_reg  <= '0;
            best_raw_reg  <= '0;
            best_pos_reg  <= '0;
            best_gold_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            best_adj_reg  <= best_adj_next;
            best_raw_reg  <= best_raw_next;
            best_pos_reg  <= best_pos_next;
            best_gold_reg <= best_gold_next;
        end
    end

endmodule

### hdl/cala_queue.sv
// ----------------------------------------------------------------------------
// cala_queue
// Short first-in first-out queue of classified records.
// ----------------------------------------------------------------------------
module cala_queue
    import cala_pkg::*;
#(
    parameter int Depth = CALA_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cala_rec_t   wr_rec,
    input  logic        pop,
    output cala_rec_t   rd_rec,
    output cala_qstat_t stat
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int NW = $clog2(Depth + 1);

    cala_rec_t     entry_reg [Depth];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        stat.full  = (count_reg == NW'(Depth));
        stat.empty = (count_reg == '0);
        rd_rec     = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/cala_back.sv
// ----------------------------------------------------------------------------
// cala_back
// Sum the cost and loss terms of each record, accumulate with saturation
// and hold node results in the output register.
// ----------------------------------------------------------------------------
module cala_back
    import cala_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cala_rec_t               rd_rec,
    input  cala_qstat_t             qstat,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [LABEL_W-1:0]      label_index,
    output logic                    label_found,
    output logic                    instance_end,
    output logic signed [ACC_W-1:0] total_cost,
    output logic signed [ACC_W-1:0] total_loss
);

    // Delta stage
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_node_end_reg, s1_inst_end_reg, s1_aug_reg, s1_found_reg;
    logic [LABEL_W-1:0]        s1_label_reg;
    logic signed [DELTA_W-1:0] s1_dcost_reg, s1_dloss_reg;
    logic signed [DELTA_W-1:0] dcost, dloss;

    // Accumulate stage
    logic signed [ACC_W-1:0]   cost_acc_reg, cost_acc_next;
    logic signed [ACC_W-1:0]   loss_acc_reg, loss_acc_next;
    logic signed [ACC_W-1:0]   cost_sum, loss_sum;
    logic                      res_valid_reg, res_valid_next;
    logic [LABEL_W-1:0]        res_label_reg;
    logic                      res_found_reg, res_inst_reg;
    logic signed [ACC_W-1:0]   res_cost_reg, res_loss_reg;
    logic                      consume, advance;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]   acc,
        input logic signed [DELTA_W-1:0] d
    );
        logic signed [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + {{(ACC_W+1-DELTA_W){d[DELTA_W-1]}}, d};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    always_comb
    begin
        dcost = DELTA_W'(signed'({1'b0, rd_rec.item_cost}))
              + {{(DELTA_W-PEN_W){rd_rec.win_pen[PEN_W-1]}}, rd_rec.win_pen};
        dloss = {{(DELTA_W-ADJ_W){rd_rec.item_loss[ADJ_W-1]}}, rd_rec.item_loss}
              + {{(DELTA_W-PEN_W){rd_rec.win_pen[PEN_W-1]}}, rd_rec.win_pen}
              + {{(DELTA_W-SCORE_W){rd_rec.win_raw[SCORE_W-1]}}, rd_rec.win_raw};

        // A non-final beat only updates the accumulators; a node end needs room
        consume = s1_valid_reg && (!s1_node_end_reg || !res_valid_reg || !result_stall);
        advance = !s1_valid_reg || consume;
        pop     = advance && !qstat.empty;

        s1_valid_next = s1_valid_reg;
        if (advance)
        begin
            s1_valid_next = !qstat.empty;
        end

        cost_sum = s1_aug_reg ? sat_add(cost_acc_reg, s1_dcost_reg) : '0;
        loss_sum = s1_aug_reg ? sat_add(loss_acc_reg, s1_dloss_reg) : '0;

        cost_acc_next = cost_acc_reg;
        loss_acc_next = loss_acc_reg;
        if (consume)
        begin
            cost_acc_next = s1_inst_end_reg ? '0 : cost_sum;
            loss_acc_next = s1_inst_end_reg ? '0 : loss_sum;
        end

        res_valid_next = res_valid_reg && result_stall;
        if (consume && s1_node_end_reg)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_node_end_reg <= rd_rec.node_end;
            s1_inst_end_reg <= rd_rec.inst_end;
            s1_aug_reg      <= rd_rec.augment;
            s1_found_reg    <= rd_rec.found;
            s1_label_reg    <= rd_rec.label;
            s1_dcost_reg    <= dcost;
            s1_dloss_reg    <= dloss;
        end
        if (consume && s1_node_end_reg)
        begin
            res_label_reg <= s1_label_reg;
            res_found_reg <= s1_found_reg;
            res_inst_reg  <= s1_inst_end_reg;
            res_cost_reg  <= cost_sum;
            res_loss_reg  <= loss_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            cost_acc_reg  <= '0;
            loss_acc_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            cost_acc_reg  <= cost_acc_next;
            loss_acc_reg  <= loss_acc_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign label_index  = res_label_reg;
    assign label_found  = res_found_reg;
    assign instance_end = res_inst_reg;
    assign total_cost   = res_cost_reg;
    assign total_loss   = res_loss_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cost_augmented_label_argmax. A scoreboard class
// predicts every node result from the accepted item beats and the register
// settings, and compares each result beat field by field. Stimulus is a
// directed set of corner items, random instances over several register
// settings, a fill-up burst, and two oversized nodes of extreme gold beats
// that swing the loss far in both directions.
// ----------------------------------------------------------------------------
module tb_top;
    import cala_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int MAX_GAP = 11;
    // Idle margin after the expected results have drained
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASE_ITEMS = 230;
    // Oversized node of gold beats, about 2^31 loss each
    localparam int SAT_RUN = 70;
    localparam int FILL_BURST = 40;
    localparam int HOLD_CYCLES = 120;
    localparam int PRINT_CAP = 50;
    // Index with no register behind it; the write must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd200;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef struct {
        logic [LABEL_W-1:0]      label;
        logic                    found;
        logic                    inst_end;
        logic signed [ACC_W-1:0] cost;
        logic signed [ACC_W-1:0] loss;
    } node_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of registers and argmax state, queue of results
    // ------------------------------------------------------------------------
    class argmax_scoreboard;
        logic [WEIGHT_W-1:0] fp_weight;
        logic [WEIGHT_W-1:0] fn_weight;
        bit                  augment;
        bit                  drop;
        longint              best_adj;
        longint              best_raw;
        int                  best_pos;
        bit                  best_gold;
        int                  cand_count;
        longint              cost_acc;
        longint              loss_acc;
        node_result_t        expected_results[$];
        int                  errors;
        int                  items_seen;
        int                  results_seen;

        function new();
            fp_weight = FP_WEIGHT_RESET;
            fn_weight = FN_WEIGHT_RESET;
            augment = 1'b1;
            drop = 1'b0;
            best_adj = 0;
            best_raw = 0;
            best_pos = 0;
            best_gold = 1'b0;
            cand_count = 0;
            cost_acc = 0;
            loss_acc = 0;
            errors = 0;
            items_seen = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FP_WEIGHT: fp_weight = data[WEIGHT_W-1:0];
                REG_FN_WEIGHT: fn_weight = data[WEIGHT_W-1:0];
                REG_AUGMENT:   augment = data[0];
                REG_DROP:      drop = data[0];
                default: ;
            endcase
        endfunction

        function longint saturate48(longint x);
            if (x > longint'(ACC_MAX))
                return longint'(ACC_MAX);
            if (x < longint'(ACC_MIN))
                return longint'(ACC_MIN);
            return x;
        endfunction

        // One saturating add per beat; with augmentation off both read zero
        function void accumulate(longint dcost, longint dloss);
            if (augment)
            begin
                cost_acc = saturate48(cost_acc + dcost);
                loss_acc = saturate48(loss_acc + dloss);
            end
            else
            begin
                cost_acc = 0;
                loss_acc = 0;
            end
        endfunction

        function void note_item(logic signed [SCORE_W-1:0] sc, logic g, logic lin, logic lii);
            longint       raw;
            longint       adj;
            longint       a;
            longint       b;
            longint       dcost;
            longint       dloss;
            longint       pen;
            bit           found;
            node_result_t r;
            raw = sc;
            a = fp_weight;
            b = fn_weight;
            adj = raw;
            dcost = 0;
            dloss = 0;
            items_seen++;
            if (augment)
            begin
                adj = g ? raw - b : raw + a;
                if (g)
                begin
                    dcost = b;
                    dloss = b - raw;
                end
            end
            // Candidates past the label limit keep their gold terms only
            if (cand_count < CALA_MAX_LABELS)
            begin
                if (cand_count == 0 || adj > best_adj)
                begin
                    best_adj = adj;
                    best_raw = raw;
                    best_pos = cand_count;
                    best_gold = g;
                end
                cand_count++;
            end
            if (!(lin || lii))
            begin
                accumulate(dcost, dloss);
                return;
            end
            found = (cand_count != 0);
            if (found && drop && best_adj <= 0)
                found = 1'b0;
            if (found && augment)
            begin
                pen = best_gold ? -b : a;
                dcost += pen;
                dloss += pen + best_raw;
            end
            accumulate(dcost, dloss);
            r.label = found ? best_pos[LABEL_W-1:0] : '0;
            r.found = found;
            r.inst_end = lii;
            r.cost = cost_acc[ACC_W-1:0];
            r.loss = loss_acc[ACC_W-1:0];
            expected_results.push_back(r);
            cand_count = 0;
            best_adj = 0;
            best_raw = 0;
            best_pos = 0;
            best_gold = 1'b0;
            if (lii)
            begin
                cost_acc = 0;
                loss_acc = 0;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [LABEL_W-1:0] label, logic found, logic inst_end,
                          logic signed [ACC_W-1:0] cost, logic signed [ACC_W-1:0] loss);
            node_result_t want;
            if (expected_results.size() == 0)
            begin
                report("result beat with nothing expected");
                return;
            end
            want = expected_results.pop_front();
            results_seen++;
            if (label !== want.label)
                report($sformatf("label_index got %0d want %0d", label, want.label));
            if (found !== want.found)
                report($sformatf("label_found got %b want %b", found, want.found));
            if (inst_end !== want.inst_end)
                report($sformatf("instance_end got %b want %b", inst_end, want.inst_end));
            if (cost !== want.cost)
                report($sformatf("total_cost got %0d want %0d", cost, want.cost));
            if (loss !== want.loss)
                report($sformatf("total_loss got %0d want %0d", loss, want.loss));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_stall;
    logic signed [SCORE_W-1:0] score;
    logic                      gold;
    logic                      last_in_node;
    logic                      last_in_instance;
    logic                      result_valid;
    logic                      result_stall;
    logic [LABEL_W-1:0]        label_index;
    logic                      label_found;
    logic                      instance_end;
    logic signed [ACC_W-1:0]   total_cost;
    logic signed [ACC_W-1:0]   total_loss;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    argmax_scoreboard sb = new();

    // Idle limits per side; zero gives a stretch with no idling
    int tx_max_gap = MAX_GAP;
    int rx_max_stall = MAX_GAP;
    // Nonzero asks the receiver for one long hold-off
    int rx_hold = 0;
    int cfg_writes = 0;

    cost_augmented_label_argmax dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .score            (score),
        .gold             (gold),
        .last_in_node     (last_in_node),
        .last_in_instance (last_in_instance),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .label_index      (label_index),
        .label_found      (label_found),
        .instance_end     (instance_end),
        .total_cost       (total_cost),
        .total_loss       (total_loss),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitors: sample at the edge, before any update of this step lands
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_item(score, gold, last_in_node, last_in_instance);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(label_index, label_found, instance_end, total_cost, total_loss);
    end

    // ------------------------------------------------------------------------
    // Receiver: stall a random count before each beat, or hold off long when
    // asked, counting the hold in this process
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold != 0)
            begin
                gap = rx_hold;
                rx_hold = 0;
            end
            else
                gap = $urandom_range(0, rx_max_stall);
            if (gap != 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one item beat after a random gap; hold it until taken
    task automatic send_item(input logic signed [SCORE_W-1:0] sc, input logic g,
                             input logic lin, input logic lii);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        score <= sc;
        gold <= g;
        last_in_node <= lin;
        last_in_instance <= lii;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no drop in between
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, data);
        cfg_writes++;
    endtask

    // Drop valid, let the monitor note the last beat, then wait out every
    // expected result and the tail of the pipe
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers; unused upper data bits are sometimes junk
    task automatic apply_config(input logic [WEIGHT_W-1:0] fp, input logic [WEIGHT_W-1:0] fn,
                                input bit aug, input bit drp);
        logic [CFG_DATA_W-1:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
        write_register(REG_FP_WEIGHT, {junk[CFG_DATA_W-1:WEIGHT_W], fp});
        write_register(REG_FN_WEIGHT, {junk[CFG_DATA_W-1:WEIGHT_W], fn});
        write_register(REG_AUGMENT, {junk[CFG_DATA_W-1:1], aug});
        write_register(REG_DROP, {junk[CFG_DATA_W-1:1], drp});
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------------

    // Mix of full-range, near-zero, extreme and weight-aligned scores, the
    // last to make ties after adjustment likely
    function automatic logic signed [SCORE_W-1:0] pick_score();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return $urandom;
        if (sel < 75)
            return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        if (sel < 85)
        begin
            case ($urandom_range(0, 4))
                0: return SCORE_MIN;
                1: return SCORE_MAX;
                2: return '0;
                3: return '1;
                default: return 1;
            endcase
        end
        return (int'($urandom_range(0, 16)) - 8) * 32768;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 17'd65536;
            2: return '1;
            3: return FP_WEIGHT_RESET;
            default: return WEIGHT_W'($urandom_range(0, (1 << WEIGHT_W) - 1));
        endcase
    endfunction

    // Mostly small nodes, a few past the label limit
    function automatic int node_size();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return $urandom_range(CALA_MAX_LABELS + 1, CALA_MAX_LABELS + 8);
        if (sel < 30)
            return 1;
        return $urandom_range(2, 8);
    endfunction

    // Usually one gold label; sometimes none or extras. When it closes the
    // instance, the last beat sometimes skips the node mark.
    task automatic send_node(input int n, input bit close_inst);
        int gold_at;
        bit skip_node_mark;
        bit g;
        gold_at = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, n - 1);
        skip_node_mark = close_inst && ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            g = (i == gold_at) || ($urandom_range(0, 19) == 0);
            send_item(pick_score(), g, (i == n - 1) && !skip_node_mark,
                      (i == n - 1) && close_inst);
        end
    endtask

    // Well-formed instance with an occasional stray beat of random marks
    task automatic send_instance();
        int nodes;
        nodes = $urandom_range(1, 5);
        for (int k = 0; k < nodes; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            send_node(node_size(), k == nodes - 1);
        end
    endtask

    // Hold the receiver off while single-label nodes stream in back to back,
    // so the record queue fills and the item side stalls
    task automatic fill_burst();
        int saved_gap;
        saved_gap = tx_max_gap;
        tx_max_gap = 0;
        rx_hold = HOLD_CYCLES;
        for (int i = 0; i < FILL_BURST; i++)
            send_item(pick_score(), 1'($urandom_range(0, 1)), 1'b1, i == FILL_BURST - 1);
        tx_max_gap = saved_gap;
    endtask

    // ------------------------------------------------------------------------
    // Phases
    // ------------------------------------------------------------------------
    task automatic run_directed();
        // Reset defaults: weights 0.5, augmentation on, no null dropping
        send_item(SCORE_MAX, 1'b1, 1'b1, 1'b1);
        // Non-gold -1 plus weight beats the most negative and a gold zero
        send_item(SCORE_MIN, 1'b0, 1'b0, 1'b0);
        send_item(0, 1'b1, 1'b0, 1'b0);
        send_item(-1, 1'b0, 1'b1, 1'b0);
        // Equal scores: the first one wins
        send_item(100, 1'b0, 1'b0, 1'b0);
        send_item(100, 1'b0, 1'b1, 1'b0);
        // Gold and non-gold tie after adjustment
        send_item(65536, 1'b1, 1'b0, 1'b0);
        send_item(0, 1'b0, 1'b1, 1'b0);
        // Instance end without a node mark closes the node too
        send_item(5, 1'b0, 1'b0, 1'b0);
        send_item(7, 1'b1, 1'b0, 1'b1);
        settle();

        // Null dropping: negative best, exactly zero best, then just above
        apply_config(FP_WEIGHT_RESET, FN_WEIGHT_RESET, 1'b1, 1'b1);
        send_item(-65536, 1'b0, 1'b0, 1'b0);
        send_item(-100000, 1'b1, 1'b1, 1'b0);
        send_item(-32768, 1'b0, 1'b1, 1'b0);
        send_item(-32767, 1'b0, 1'b1, 1'b1);
        settle();

        // Augmentation off: raw scores decide and totals read zero
        apply_config(FP_WEIGHT_RESET, FN_WEIGHT_RESET, 1'b0, 1'b1);
        send_item(0, 1'b0, 1'b1, 1'b0);
        send_item(5, 1'b1, 1'b1, 1'b1);
        settle();
        apply_config(FP_WEIGHT_RESET, FN_WEIGHT_RESET, 1'b0, 1'b0);
        send_item(SCORE_MIN, 1'b0, 1'b1, 1'b1);
        settle();

        // All-ones data truncates to the widest weight; a spare index is ignored
        write_register(REG_FP_WEIGHT, '1);
        write_register(REG_SPARE, $urandom);
        write_register(REG_AUGMENT, 32'd1);
        cfg_valid <= 1'b0;
        send_item(SCORE_MAX, 1'b0, 1'b1, 1'b1);
        settle();
    endtask

    task automatic run_random();
        int target;
        int phase_end;
        bit paused;
        target = sb.items_seen + RANDOM_ITEMS;
        for (int phase = 0; sb.items_seen < target; phase++)
        begin
            settle();
            case (phase)
                0: apply_config('0, '1, 1'b1, 1'b0);
                1: apply_config('1, '0, 1'b1, 1'b1);
                2: apply_config(17'd65536, 17'd65536, 1'b1, 1'b1);
                3: apply_config(pick_weight(), pick_weight(), 1'b0, 1'b0);
                4: apply_config(pick_weight(), pick_weight(), 1'b0, 1'b1);
                default: apply_config(pick_weight(), pick_weight(),
                                      $urandom_range(0, 3) != 0,
                                      1'($urandom_range(0, 1)));
            endcase
            // Rotate idle patterns so some phases run without any gaps
            tx_max_gap = (phase % 3 == 2) ? 0 : MAX_GAP;
            rx_max_stall = (phase % 4 == 3) ? 0 : MAX_GAP;
            if (phase == 1)
                fill_burst();
            phase_end = sb.items_seen + PHASE_ITEMS;
            paused = 1'b0;
            while (sb.items_seen < phase_end && sb.items_seen < target)
            begin
                send_instance();
                // Even phases pause the sender once mid-way until all is drained
                if (!paused && phase % 2 == 0 && sb.items_seen >= phase_end - PHASE_ITEMS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end
        settle();
        tx_max_gap = MAX_GAP;
        rx_max_stall = MAX_GAP;
    endtask

    // One oversized node per direction: gold beats at the score limits whose
    // loss terms pile up to large totals of either sign
    task automatic run_extreme_loss();
        tx_max_gap = 0;
        rx_max_stall = 0;
        apply_config('0, '1, 1'b1, 1'b0);
        for (int i = 0; i < SAT_RUN; i++)
            send_item(SCORE_MIN, 1'b1, i == SAT_RUN - 1, i == SAT_RUN - 1);
        settle();
        apply_config('0, '0, 1'b1, 1'b0);
        for (int i = 0; i < SAT_RUN; i++)
            send_item(SCORE_MAX, 1'b1, i == SAT_RUN - 1, i == SAT_RUN - 1);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        score <= '0;
        gold <= 1'b0;
        last_in_node <= 1'b0;
        last_in_instance <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        run_extreme_loss();

        if (sb.expected_results.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.expected_results.size()));
        $display("covered %0d item beats and %0d node results over %0d register writes,",
                 sb.items_seen, sb.results_seen, cfg_writes);
        $display("incl. ties, null labels, oversized nodes, fill-up stalls, large loss swings");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #(CLK_PERIOD * 2000000);
        $display("watchdog expired with %0d results outstanding", sb.expected_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
